@@ hdl/sensor_sample_admission_filter_assert.svh @@
// Assertion macros used by the checker of the sensor sample admission filter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SENSOR_SAMPLE_ADMISSION_FILTER_ASSERT_SVH
`define SENSOR_SAMPLE_ADMISSION_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSAF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssaf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssaf assertion failed");

`endif

@@ hdl/ssaf_pkg.sv @@
// Types and codes of the sensor sample admission filter.
// No dependencies; every other file of the block but the assertion header imports this package.
package ssaf_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_EPOCH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        DISP_ACCEPTED   = 3'd0,
        DISP_IGNORED    = 3'd1,
        DISP_NO_SEQ     = 3'd2,
        DISP_STALE      = 3'd3,
        DISP_INCOMPLETE = 3'd4,
        DISP_DUPLICATE  = 3'd5,
        DISP_BACK       = 3'd6,
        DISP_CMD        = 3'd7
    } disp_t;

    localparam logic [2:0] FULL_CHANNELS = 3'd6;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] frame_seq;
        logic        frame_seq_valid;
        logic [31:0] sensor_counter;
        logic        sensor_counter_valid;
        logic        status_ok;
        logic        temperature_ok;
        logic [2:0]  channels_ok;
        logic [47:0] timestamp_us;
    } item_t;

    typedef struct packed {
        logic [31:0] received_total;
        logic [31:0] rejected_total;
        logic [31:0] complete_total;
        logic [31:0] duplicate_total;
        logic [31:0] accepted_total;
        logic [47:0] missing_total;
    } totals_t;

    typedef struct packed {
        disp_t       disposition;
        logic [30:0] frames_missed_now;
        logic [31:0] received_total;
        logic [31:0] rejected_total;
        logic [31:0] complete_total;
        logic [31:0] duplicate_total;
        logic [31:0] accepted_total;
        logic [47:0] missing_total;
    } result_t;

    // Tracking state seen by the decision logic.
    typedef struct packed {
        logic        monitoring_on;
        logic [31:0] last_frame;
        logic        last_frame_known;
        logic [31:0] last_counter;
        logic        last_counter_known;
    } track_t;

    // Update requests from the decision logic to the state registers.
    typedef struct packed {
        logic        clear_all;
        logic        mon_set;
        logic        mon_clr;
        logic        frame_clr;
        logic        frame_load;
        logic        counter_load;
        logic        inc_received;
        logic        inc_rejected;
        logic        inc_complete;
        logic        inc_duplicate;
        logic        inc_accepted;
        logic        add_missing;
        logic [30:0] gap;
    } update_t;

endpackage

@@ hdl/ssaf_ifs.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on ssaf_pkg for the payload types.
interface ssaf_item_if;
    import ssaf_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssaf_result_if;
    import ssaf_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sensor_sample_admission_filter.sv @@
// Sensor sample admission filter.
//
// Channels: item (sink) takes commands and trace samples; result (source)
// gives one result per item, in order, with its disposition and all totals.
// A transfer happens on a rising edge of clk with valid and ready both high.
//
// Timing: an item lands in the input register at its transfer, and its
// result is registered in the result register once that register is free
// or its current result is being taken by the receiver.
// Throughput is one item per cycle while the receiver does not stall: the
// decision is a subtract and compare against the tracking registers, which
// update in the same cycle the result is registered.
//
// When the receiver stalls, the result register holds and the input register
// keeps one further item; item.ready drops only while both are full.
//
// Reset (rst_n low, asynchronous) empties both registers, turns monitoring
// off, forgets the last frame and counter, and clears all totals.
// Depends on ssaf_pkg, ssaf_ifs, ssaf_eval and ssaf_state.
module sensor_sample_admission_filter (
    input logic         clk,
    input logic         rst_n,
    ssaf_item_if.sink   item,
    ssaf_result_if.source result
);
    import ssaf_pkg::*;

    logic    in_vld_reg;
    item_t   in_data_reg;
    logic    out_vld_reg;
    result_t out_data_reg;
    logic    advance;
    update_t upd;
    track_t  track;
    totals_t totals_next;
    disp_t   disposition;
    logic [30:0] frames_missed_now;

    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || advance;

    ssaf_eval u_eval (
        .item              (in_data_reg),
        .track             (track),
        .upd               (upd),
        .disposition       (disposition),
        .frames_missed_now (frames_missed_now)
    );

    ssaf_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .frame_seq      (in_data_reg.frame_seq),
        .sensor_counter (in_data_reg.sensor_counter),
        .upd            (upd),
        .track          (track),
        .totals_next    (totals_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_data_reg <= item.data;
        end
        if (advance)
        begin
            out_data_reg.disposition       <= disposition;
            out_data_reg.frames_missed_now <= frames_missed_now;
            out_data_reg.received_total    <= totals_next.received_total;
            out_data_reg.rejected_total    <= totals_next.rejected_total;
            out_data_reg.complete_total    <= totals_next.complete_total;
            out_data_reg.duplicate_total   <= totals_next.duplicate_total;
            out_data_reg.accepted_total    <= totals_next.accepted_total;
            out_data_reg.missing_total     <= totals_next.missing_total;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;
endmodule

@@ hdl/ssaf_eval.sv @@
// Decision logic: classifies one item against the tracking state.
// Purely combinational; depends on ssaf_pkg.
module ssaf_eval (
    input  ssaf_pkg::item_t   item,
    input  ssaf_pkg::track_t  track,
    output ssaf_pkg::update_t upd,
    output ssaf_pkg::disp_t   disposition,
    output logic [30:0]       frames_missed_now
);
    import ssaf_pkg::*;

    logic [31:0] step;
    logic [31:0] inc;
    logic [31:0] gap_full;
    logic        stale;
    logic        gap_present;
    logic        complete;
    logic        dup;
    logic        back;

    // Serial arithmetic: a difference with the top bit set lies behind.
    assign step        = item.frame_seq - track.last_frame;
    assign gap_full    = step - 32'd1;
    assign stale       = track.last_frame_known && ((step == 32'd0) || step[31]);
    assign gap_present = track.last_frame_known && !step[31] && (step > 32'd1);
    assign complete    = (item.channels_ok == FULL_CHANNELS) && (item.timestamp_us != 48'd0)
                         && item.status_ok && item.sensor_counter_valid
                         && item.temperature_ok;
    assign inc         = item.sensor_counter - track.last_counter;
    assign dup         = track.last_counter_known && (inc == 32'd0);
    assign back        = track.last_counter_known && inc[31];

    always_comb
    begin
        upd               = '0;
        disposition       = DISP_CMD;
        frames_missed_now = '0;
        case (item.cmd)
            CMD_START:
            begin
                upd.clear_all = 1'b1;
                upd.mon_set   = 1'b1;
            end
            CMD_STOP:
            begin
                upd.mon_clr = 1'b1;
            end
            CMD_EPOCH:
            begin
                upd.frame_clr = 1'b1;
            end
            CMD_SAMPLE:
            begin
                if (!track.monitoring_on)
                begin
                    disposition = DISP_IGNORED;
                end
                else
                begin
                    upd.inc_received = 1'b1;
                    if (!item.frame_seq_valid)
                    begin
                        upd.inc_rejected = 1'b1;
                        disposition      = DISP_NO_SEQ;
                    end
                    else if (stale)
                    begin
                        upd.inc_rejected = 1'b1;
                        disposition      = DISP_STALE;
                    end
                    else
                    begin
                        upd.frame_load = 1'b1;
                        if (gap_present)
                        begin
                            upd.add_missing   = 1'b1;
                            upd.gap           = gap_full[30:0];
                            frames_missed_now = gap_full[30:0];
                        end
                        if (!complete)
                        begin
                            upd.inc_rejected = 1'b1;
                            disposition      = DISP_INCOMPLETE;
                        end
                        else
                        begin
                            upd.inc_complete = 1'b1;
                            if (dup)
                            begin
                                upd.inc_duplicate = 1'b1;
                                disposition       = DISP_DUPLICATE;
                            end
                            else if (back)
                            begin
                                upd.inc_rejected = 1'b1;
                                disposition      = DISP_BACK;
                            end
                            else
                            begin
                                upd.counter_load = 1'b1;
                                upd.inc_accepted = 1'b1;
                                disposition      = DISP_ACCEPTED;
                            end
                        end
                    end
                end
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end
endmodule

@@ hdl/ssaf_state.sv @@
// Tracking registers and saturating counters of the admission filter.
// Depends on ssaf_pkg; applies the updates requested by ssaf_eval.
module ssaf_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [31:0]       frame_seq,
    input  logic [31:0]       sensor_counter,
    input  ssaf_pkg::update_t upd,
    output ssaf_pkg::track_t  track,
    output ssaf_pkg::totals_t totals_next
);
    import ssaf_pkg::*;

    track_t  track_reg;
    track_t  track_next;
    totals_t totals_reg;
    logic [48:0] missing_sum;

    function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic doit);
        logic [31:0] r;
        r = v;
        if (doit && (v != '1))
        begin
            r = v + 32'd1;
        end
        return r;
    endfunction

    assign missing_sum = {1'b0, totals_reg.missing_total} + {18'd0, upd.gap};

    always_comb
    begin
        track_next  = track_reg;
        totals_next = totals_reg;
        if (upd.clear_all)
        begin
            track_next  = '0;
            totals_next = '0;
        end
        if (upd.mon_set)
        begin
            track_next.monitoring_on = 1'b1;
        end
        if (upd.mon_clr)
        begin
            track_next.monitoring_on = 1'b0;
        end
        if (upd.frame_clr)
        begin
            track_next.last_frame       = '0;
            track_next.last_frame_known = 1'b0;
        end
        if (upd.frame_load)
        begin
            track_next.last_frame       = frame_seq;
            track_next.last_frame_known = 1'b1;
        end
        if (upd.counter_load)
        begin
            track_next.last_counter       = sensor_counter;
            track_next.last_counter_known = 1'b1;
        end
        if (!upd.clear_all)
        begin
            totals_next.received_total  = sat_inc(totals_reg.received_total, upd.inc_received);
            totals_next.rejected_total  = sat_inc(totals_reg.rejected_total, upd.inc_rejected);
            totals_next.complete_total  = sat_inc(totals_reg.complete_total, upd.inc_complete);
            totals_next.duplicate_total = sat_inc(totals_reg.duplicate_total,
                                                  upd.inc_duplicate);
            totals_next.accepted_total  = sat_inc(totals_reg.accepted_total, upd.inc_accepted);
            if (upd.add_missing)
            begin
                totals_next.missing_total = missing_sum[48] ? '1 : missing_sum[47:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg  <= '0;
            totals_reg <= '0;
        end
        else if (en)
        begin
            track_reg  <= track_next;
            totals_reg <= totals_next;
        end
    end

    assign track = track_reg;
endmodule

@@ hdl/ssaf_checker.sv @@
// Port-level checker for the sensor sample admission filter, bound to the top.
// Depends on ssaf_pkg and sensor_sample_admission_filter_assert.svh.
`include "sensor_sample_admission_filter_assert.svh"

module ssaf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input ssaf_pkg::result_t result_data
);
    import ssaf_pkg::*;

    logic stalled;
    logic totals_in_range;
    logic dup_in_range;
    logic acc_or_cmd;
    logic disp_consistent;

    assign stalled         = result_valid && !result_ready;
    assign totals_in_range = (result_data.rejected_total <= result_data.received_total)
                             && (result_data.accepted_total <= result_data.received_total);
    assign dup_in_range    = result_data.duplicate_total <= result_data.complete_total;
    assign acc_or_cmd      = result_valid && ((result_data.disposition == DISP_ACCEPTED)
                             || (result_data.disposition == DISP_CMD));
    assign disp_consistent = (result_data.disposition == DISP_CMD)
                             ? (result_data.frames_missed_now == 31'd0)
                             : (result_data.accepted_total != 32'd0);

    // A stalled result stays on the port unchanged.
    `SSAF_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(result_data))

    // Rejected and accepted samples are always a subset of received samples.
    `SSAF_ASSERT_NOW(a_totals_order, result_valid, totals_in_range)

    // Duplicates are counted among complete frames.
    `SSAF_ASSERT_NOW(a_dup_le_complete, result_valid, dup_in_range)

    // An accepted sample has been counted, and a command reports no gap.
    `SSAF_ASSERT_NOW(a_disp_totals, acc_or_cmd, disp_consistent)
endmodule

bind sensor_sample_admission_filter ssaf_checker u_ssaf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

@@ tb/tb_sensor_sample_admission_filter.sv @@
// Self-checking testbench for the sensor sample admission filter.
// Depends on ssaf_pkg, the channel interfaces in ssaf_ifs and the block's RTL.
module tb_sensor_sample_admission_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import ssaf_pkg::*;

    localparam int unsigned EXP_DEPTH = 64;

    logic clk;
    logic rst_n;

    ssaf_item_if   item_ch ();
    ssaf_result_if res_ch ();

    sensor_sample_admission_filter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Copy of the filter state kept by the predictor.
    logic        mon_on;
    logic [31:0] prev_frame;
    logic        prev_frame_known;
    logic [31:0] prev_ctr;
    logic        prev_ctr_known;
    totals_t     tally;

    // Expected results in transfer order, kept in a ring.
    result_t     exp_mem[EXP_DEPTH];
    int unsigned exp_wr_cnt;
    int unsigned exp_rd_cnt;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned disp_seen[8];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned stall_left;

    always #4 clk = ~clk;

    function automatic int unsigned pending_count();
        return exp_wr_cnt - exp_rd_cnt;
    endfunction

    function automatic void exp_store(input result_t r);
        exp_mem[exp_wr_cnt % EXP_DEPTH] = r;
        exp_wr_cnt++;
    endfunction

    function automatic result_t exp_take();
        result_t r;
        r = exp_mem[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        return r;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Applies one item to the predictor state and returns the result it causes.
    function automatic result_t admit_item(input item_t it);
        result_t     r;
        disp_t       disp;
        logic [31:0] step;
        logic [31:0] inc;
        logic [48:0] sum;
        logic        complete;
        r = '0;
        disp = DISP_CMD;
        case (it.cmd)
            CMD_START:
            begin
                prev_frame = '0;
                prev_frame_known = 1'b0;
                prev_ctr = '0;
                prev_ctr_known = 1'b0;
                tally = '0;
                mon_on = 1'b1;
            end
            CMD_STOP:
            begin
                mon_on = 1'b0;
            end
            CMD_EPOCH:
            begin
                prev_frame = '0;
                prev_frame_known = 1'b0;
            end
            default:
            begin
                if (!mon_on) begin
                    disp = DISP_IGNORED;
                end else begin
                    tally.received_total = sat_inc32(tally.received_total);
                    step = it.frame_seq - prev_frame;
                    if (!it.frame_seq_valid) begin
                        disp = DISP_NO_SEQ;
                    end else if (prev_frame_known && (step == 32'd0 || step[31])) begin
                        disp = DISP_STALE;
                    end else begin
                        if (prev_frame_known && step > 32'd1) begin
                            r.frames_missed_now = 31'(step - 32'd1);
                            sum = {1'b0, tally.missing_total} + 49'(step - 32'd1);
                            tally.missing_total = sum[48] ? {48{1'b1}} : sum[47:0];
                        end
                        prev_frame = it.frame_seq;
                        prev_frame_known = 1'b1;
                        complete = it.channels_ok == FULL_CHANNELS && it.timestamp_us != '0
                                   && it.status_ok && it.sensor_counter_valid
                                   && it.temperature_ok;
                        inc = it.sensor_counter - prev_ctr;
                        if (!complete) begin
                            disp = DISP_INCOMPLETE;
                        end else begin
                            tally.complete_total = sat_inc32(tally.complete_total);
                            if (prev_ctr_known && inc == 32'd0) begin
                                disp = DISP_DUPLICATE;
                                tally.duplicate_total = sat_inc32(tally.duplicate_total);
                            end else if (prev_ctr_known && inc[31]) begin
                                disp = DISP_BACK;
                            end else begin
                                prev_ctr = it.sensor_counter;
                                prev_ctr_known = 1'b1;
                                tally.accepted_total = sat_inc32(tally.accepted_total);
                                disp = DISP_ACCEPTED;
                            end
                        end
                    end
                    if (disp inside {DISP_NO_SEQ, DISP_STALE, DISP_INCOMPLETE, DISP_BACK}) begin
                        tally.rejected_total = sat_inc32(tally.rejected_total);
                    end
                end
            end
        endcase
        r.disposition     = disp;
        r.received_total  = tally.received_total;
        r.rejected_total  = tally.rejected_total;
        r.complete_total  = tally.complete_total;
        r.duplicate_total = tally.duplicate_total;
        r.accepted_total  = tally.accepted_total;
        r.missing_total   = tally.missing_total;
        return r;
    endfunction

    function automatic item_t good_sample(input logic [31:0] seq, input logic [31:0] ctr);
        item_t it;
        it = '0;
        it.cmd = CMD_SAMPLE;
        it.frame_seq = seq;
        it.frame_seq_valid = 1'b1;
        it.sensor_counter = ctr;
        it.sensor_counter_valid = 1'b1;
        it.status_ok = 1'b1;
        it.temperature_ok = 1'b1;
        it.channels_ok = FULL_CHANNELS;
        it.timestamp_us = 48'd1000;
        return it;
    endfunction

    function automatic item_t command(input cmd_t c);
        item_t it;
        it = '0;
        it.cmd = c;
        return it;
    endfunction

    // Mostly well-formed traffic that follows the predicted frame and counter,
    // mixed with commands, stale or broken samples and plain noise.
    function automatic item_t random_item();
        item_t       it;
        int unsigned kind;
        int unsigned roll;
        logic [31:0] step;
        it.cmd = cmd_t'(2'($urandom));
        it.frame_seq = $urandom;
        it.frame_seq_valid = 1'($urandom);
        it.sensor_counter = $urandom;
        it.sensor_counter_valid = 1'($urandom);
        it.status_ok = 1'($urandom);
        it.temperature_ok = 1'($urandom);
        it.channels_ok = 3'($urandom);
        it.timestamp_us = {16'($urandom), $urandom};
        kind = $urandom_range(99);
        if (!mon_on && kind >= 40) begin
            it.cmd = CMD_START;
        end else if (kind < 2) begin
            it.cmd = CMD_START;
        end else if (kind < 4) begin
            it.cmd = CMD_STOP;
        end else if (kind < 7) begin
            it.cmd = CMD_EPOCH;
        end else if (kind < 11) begin
            it.cmd = CMD_SAMPLE;
            it.frame_seq_valid = 1'b0;
        end else if (kind >= 15) begin
            roll = $urandom_range(99);
            if (roll < 70)
                step = 32'd1;
            else if (roll < 84)
                step = $urandom_range(9, 2);
            else if (roll < 92)
                step = $urandom_range(32'h7FFF_FFFF, 10);
            else if (roll < 96)
                step = 32'd0;
            else
                step = {1'b1, 31'($urandom)};
            it.cmd = CMD_SAMPLE;
            it.frame_seq = prev_frame + step;
            it.frame_seq_valid = 1'b1;
            roll = $urandom_range(99);
            if (roll < 80)
                it.sensor_counter = prev_ctr + 32'd1;
            else if (roll < 86)
                it.sensor_counter = prev_ctr + $urandom_range(1000, 2);
            else if (roll < 92)
                it.sensor_counter = prev_ctr;
            else if (roll < 97)
                it.sensor_counter = prev_ctr - $urandom_range(1000, 1);
            else
                it.sensor_counter = prev_ctr + {1'b1, 31'($urandom)};
            it.sensor_counter_valid = 1'b1;
            it.status_ok = 1'b1;
            it.temperature_ok = 1'b1;
            it.channels_ok = FULL_CHANNELS;
            if (it.timestamp_us == '0)
                it.timestamp_us = 48'd1;
            // Break one completeness field now and then.
            case ($urandom_range(24))
                0: it.channels_ok = 3'($urandom_range(7));
                1: it.timestamp_us = '0;
                2: it.status_ok = 1'b0;
                3: it.sensor_counter_valid = 1'b0;
                4: it.temperature_ok = 1'b0;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR %0t ns: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input int unsigned idx,
                                 input logic [47:0] got, input logic [47:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      idx, name, got, want));
    endtask

    // Sends one item and records its expected result once the transfer happens.
    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge clk); while (!item_ch.ready);
        exp_store(admit_item(it));
        items_sent++;
    endtask

    task automatic wait_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: random stalls, or a counted hold-off when stall_left is set.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (pending_count() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
            end else begin
                want = exp_take();
                compare_field("disposition", results_seen, 48'(got.disposition),
                              48'(want.disposition));
                compare_field("frames_missed_now", results_seen,
                              48'(got.frames_missed_now), 48'(want.frames_missed_now));
                compare_field("received_total", results_seen, 48'(got.received_total),
                              48'(want.received_total));
                compare_field("rejected_total", results_seen, 48'(got.rejected_total),
                              48'(want.rejected_total));
                compare_field("complete_total", results_seen, 48'(got.complete_total),
                              48'(want.complete_total));
                compare_field("duplicate_total", results_seen, 48'(got.duplicate_total),
                              48'(want.duplicate_total));
                compare_field("accepted_total", results_seen, 48'(got.accepted_total),
                              48'(want.accepted_total));
                compare_field("missing_total", results_seen, got.missing_total,
                              want.missing_total);
                disp_seen[want.disposition]++;
            end
            results_seen++;
        end
    end

    task automatic test_idle_block();
        item_t it;
        it = '1;
        it.cmd = CMD_SAMPLE;
        send_item(it);
        send_item(command(CMD_STOP));
        send_item(command(CMD_EPOCH));
        wait_results();
    endtask

    task automatic test_sample_rules();
        item_t it;
        send_item(command(CMD_START));
        it = good_sample(32'd1, 32'd1);
        it.frame_seq_valid = 1'b0;
        send_item(it);
        it = good_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it.timestamp_us = {48{1'b1}};
        send_item(it);
        // The sequence and the counter both wrap through zero here.
        send_item(good_sample(32'd0, 32'd0));
        send_item(good_sample(32'd0, 32'd1));
        send_item(good_sample(32'hFFFF_FFF0, 32'd1));
        send_item(good_sample(32'h8000_0000, 32'd1));
        it = good_sample(32'd5, 32'd1);
        it.channels_ok = 3'd5;
        send_item(it);
        it = good_sample(32'd6, 32'd1);
        it.channels_ok = 3'd7;
        send_item(it);
        it = good_sample(32'd7, 32'd1);
        it.timestamp_us = '0;
        send_item(it);
        it = good_sample(32'd8, 32'd1);
        it.status_ok = 1'b0;
        send_item(it);
        it = good_sample(32'd9, 32'd1);
        it.temperature_ok = 1'b0;
        send_item(it);
        it = good_sample(32'd10, 32'd1);
        it.sensor_counter_valid = 1'b0;
        send_item(it);
        send_item(good_sample(32'd11, 32'd0));
        send_item(good_sample(32'd12, 32'hFFFF_FFFF));
        send_item(good_sample(32'd13, 32'h8000_0000));
        // Largest forward step of both the sequence and the counter.
        send_item(good_sample(32'd13 + 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(command(CMD_EPOCH));
        send_item(good_sample(32'd3, 32'h8000_0000));
        send_item(command(CMD_STOP));
        send_item(good_sample(32'd4, 32'h8000_0001));
        send_item(command(CMD_START));
        send_item(good_sample(32'd4, 32'd9));
        wait_results();
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) send_item(random_item());
        wait_results();
    endtask

    task automatic test_random_traffic();
        src_idle_pct = 24;
        snk_idle_pct = 77;
        run_random(540);
        src_idle_pct = 77;
        snk_idle_pct = 24;
        run_random(540);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(540);
    endtask

    // The receiver holds off while items keep coming, so the block must stall
    // its input once both of its registers are full.
    task automatic test_result_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_left = 120;
        repeat (40) send_item(random_item());
        wait_results();
    endtask

    // Back-to-back maximum gaps add large values into the missing total.
    task automatic test_missing_large_gaps();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_item(command(CMD_START));
        repeat (16)
            send_item(good_sample(prev_frame + 32'h7FFF_FFFF, prev_ctr + 32'd1));
        wait_results();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        mon_on = 1'b0;
        prev_frame = '0;
        prev_frame_known = 1'b0;
        prev_ctr = '0;
        prev_ctr_known = 1'b0;
        tally = '0;
        exp_wr_cnt = 0;
        exp_rd_cnt = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_block();
        test_sample_rules();
        test_random_traffic();
        test_result_backpressure();
        test_missing_large_gaps();

        $display("Covered %0d items and %0d results, including a result hold-off",
                 items_sent, results_seen);
        $display("Outcomes: accepted %0d, ignored %0d, no seq %0d, stale %0d, incomplete %0d",
                 disp_seen[DISP_ACCEPTED], disp_seen[DISP_IGNORED], disp_seen[DISP_NO_SEQ],
                 disp_seen[DISP_STALE], disp_seen[DISP_INCOMPLETE]);
        if (mismatches == 0 && pending_count() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending_count());
        $display("simulation failed");
        $finish;
    end

endmodule
